@@ rtl/sql_keyword_tokenizer_unit_defines.svh @@
// Assertion macros shared by the tokenizer modules.
// Depends on the signals clk and arst_n being present in the using module.
`ifndef SQL_KEYWORD_TOKENIZER_UNIT_DEFINES_SVH
`define SQL_KEYWORD_TOKENIZER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SKT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SKT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SKT_ASSERT_IMP(lbl, ante, cons, msg)
`define SKT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/skt_pkg.sv @@
// Shared types, token codes and keyword table for the SQL keyword tokenizer.
// No dependencies.
package skt_pkg;

	localparam int WORD_CHARS_DEF = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int NUM_KEYS = 15;

	localparam logic [4:0] TK_IDENT = 5'd15;
	localparam logic [4:0] TK_INT = 5'd16;
	localparam logic [4:0] TK_LPAREN = 5'd17;
	localparam logic [4:0] TK_RPAREN = 5'd18;
	localparam logic [4:0] TK_SEMI = 5'd19;
	localparam logic [4:0] TK_STAR = 5'd20;
	localparam logic [4:0] TK_COMMA = 5'd21;
	localparam logic [4:0] TK_END = 5'd22;
	localparam logic [4:0] TK_UNKNOWN = 5'd23;

	localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

	localparam logic [63:0] KEY_STR [NUM_KEYS] = '{
		64'("select"), 64'("create"), 64'("insert"), 64'("into"), 64'("table"),
		64'("values"), 64'("from"), 64'("int"), 64'("double"), 64'("varchar"),
		64'("using"), 64'("btree"), 64'("hash"), 64'("update"), 64'("where")
	};
	localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{
		4'd6, 4'd6, 4'd6, 4'd4, 4'd5, 4'd6, 4'd4, 4'd3, 4'd6, 4'd7, 4'd5, 4'd5,
		4'd4, 4'd6, 4'd5
	};

	typedef struct packed {
		logic [4:0] kind;
		logic [63:0] text;
		logic [7:0] len;
		logic [30:0] val;
		logic sat;
	} token_t;

	typedef struct packed {
		token_t tok0;
		logic v0;
		token_t tok1;
		logic v1;
		logic fin;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Keyword text with its first character in the low byte.
	function automatic logic [63:0] key_packed(input int k);
		logic [63:0] res;
		int len;
		res = '0;
		len = int'(KEY_LEN[k]);
		for (int i = 0; i < 8; i++) begin
			if (i < len) begin
				res[8*i +: 8] = KEY_STR[k][8*(len-1-i) +: 8];
			end
		end
		return res;
	endfunction

	function automatic logic [4:0] match_kind(input logic [63:0] text, input logic [7:0] len);
		logic [4:0] kind;
		kind = TK_IDENT;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (len == {4'b0, KEY_LEN[k]} && text == key_packed(k)) begin
				kind = 5'(k);
			end
		end
		return kind;
	endfunction

endpackage

@@ rtl/sql_keyword_tokenizer_unit.sv @@
// Top level of the SQL keyword tokenizer: front scanner, bundle queue, back serializer.
// Depends on skt_pkg, skt_front, skt_queue and skt_back.
//
// Channel  Handshake            Payload
// input    in_valid / in_ready  character, end_of_text
// output   out_valid/out_ready  token_kind, word_text, word_length, number_value,
//                               number_saturated, last_of_run
//
// A character is scanned in the cycle it is accepted; its tokens leave one per cycle
// while out_ready is high, through the bundle queue and then the output register.
// Sustained input rate is one character per cycle while out_ready stays high and
// characters make one token at most; two or three tokens of one byte leave in turn.
// The front stalls only when the four-entry bundle queue is full.
// Reset clears the scanner, the queue and the output valid.
module sql_keyword_tokenizer_unit import skt_pkg::*; #(
	parameter int WORD_CHARS = WORD_CHARS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] character,
	input logic end_of_text,
	output logic out_valid,
	input logic out_ready,
	output logic [4:0] token_kind,
	output logic [63:0] word_text,
	output logic [7:0] word_length,
	output logic [30:0] number_value,
	output logic number_saturated,
	output logic last_of_run
);

	logic push, pop;
	bundle_t push_data, head;
	q_stat_t q_stat;

	skt_front #(
		.WORD_CHARS(WORD_CHARS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.character(character),
		.end_of_text(end_of_text),
		.q_stat(q_stat),
		.push(push),
		.push_data(push_data)
	);

	skt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.head(head),
		.q_stat(q_stat)
	);

	skt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_stat(q_stat),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.word_text(word_text),
		.word_length(word_length),
		.number_value(number_value),
		.number_saturated(number_saturated),
		.last_of_run(last_of_run)
	);

endmodule

@@ rtl/skt_front.sv @@
// Front part: accepts characters, tracks the open word or number and
// classifies the bytes into a bundle of up to three tokens. Uses skt_pkg.
`include "sql_keyword_tokenizer_unit_defines.svh"
module skt_front import skt_pkg::*; #(
	parameter int WORD_CHARS = WORD_CHARS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] character,
	input logic end_of_text,
	input q_stat_t q_stat,
	output logic push,
	output bundle_t push_data
);

	localparam int STORE = (WORD_CHARS < 8) ? WORD_CHARS : 8;
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_WORD = 2'd1;
	localparam logic [1:0] MODE_NUM = 2'd2;

	logic [1:0] mode_q, n_mode;
	logic [63:0] chars_q, n_chars, chars_add;
	logic [7:0] count_q, n_count, count_add;
	logic [30:0] acc_q, n_acc;
	logic over_q, n_over;

	logic [7:0] c;
	logic letter, digit, blank, cont_word, cont_num, flush1;
	logic [3:0] dig;
	logic [34:0] acc_ext, acc_next;
	bundle_t b;
	logic accept;

	always_comb begin
		c = character;
		if (c inside {["A":"Z"]}) begin
			c = c + 8'd32;
		end
		letter = c inside {["a":"z"]};
		digit = c inside {["0":"9"]};
		blank = (c == " ") || (c == 8'h09);
		dig = c[3:0];
		cont_word = (mode_q == MODE_WORD) && (letter || digit);
		cont_num = (mode_q == MODE_NUM) && digit;
		flush1 = !(cont_word || cont_num);

		acc_ext = {4'b0, acc_q};
		acc_next = (acc_ext << 3) + (acc_ext << 1) + {31'b0, dig};

		chars_add = chars_q;
		for (int i = 0; i < 8; i++) begin
			if (i < STORE && count_q == 8'(i)) begin
				chars_add[8*i +: 8] = c;
			end
		end
		count_add = (count_q == 8'hFF) ? count_q : count_q + 8'd1;

		n_mode = mode_q;
		n_chars = chars_q;
		n_count = count_q;
		n_acc = acc_q;
		n_over = over_q;
		if (cont_word) begin
			n_chars = chars_add;
			n_count = count_add;
		end else if (cont_num) begin
			if (acc_next > {4'b0, NUM_MAX}) begin
				n_acc = NUM_MAX;
				n_over = 1'b1;
			end else begin
				n_acc = acc_next[30:0];
			end
		end else begin
			n_mode = MODE_IDLE;
			n_chars = '0;
			n_count = '0;
			n_acc = '0;
			n_over = 1'b0;
			if (letter) begin
				n_mode = MODE_WORD;
				n_chars = {56'b0, c};
				n_count = 8'd1;
			end else if (digit) begin
				n_mode = MODE_NUM;
				n_acc = {27'b0, dig};
			end
		end

		b = '0;
		b.v0 = flush1 && (mode_q != MODE_IDLE);
		if (mode_q == MODE_WORD) begin
			b.tok0.kind = match_kind(chars_q, count_q);
			b.tok0.text = chars_q;
			b.tok0.len = count_q;
		end else begin
			b.tok0.kind = TK_INT;
			b.tok0.val = acc_q;
			b.tok0.sat = over_q;
		end

		if (end_of_text && n_mode == MODE_WORD) begin
			b.v1 = 1'b1;
			b.tok1.kind = match_kind(n_chars, n_count);
			b.tok1.text = n_chars;
			b.tok1.len = n_count;
		end else if (end_of_text && n_mode == MODE_NUM) begin
			b.v1 = 1'b1;
			b.tok1.kind = TK_INT;
			b.tok1.val = n_acc;
			b.tok1.sat = n_over;
		end else if (flush1 && !letter && !digit && !blank) begin
			b.v1 = 1'b1;
			case (c)
				"(": b.tok1.kind = TK_LPAREN;
				")": b.tok1.kind = TK_RPAREN;
				";": b.tok1.kind = TK_SEMI;
				"*": b.tok1.kind = TK_STAR;
				",": b.tok1.kind = TK_COMMA;
				default: b.tok1.kind = TK_UNKNOWN;
			endcase
		end
		b.fin = end_of_text;
	end

	assign in_ready = !q_stat.full;
	assign accept = in_valid && in_ready;
	assign push = accept && (b.v0 || b.v1 || b.fin);
	assign push_data = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			chars_q <= '0;
			count_q <= '0;
			acc_q <= '0;
			over_q <= 1'b0;
		end else if (accept) begin
			if (end_of_text) begin
				mode_q <= MODE_IDLE;
				chars_q <= '0;
				count_q <= '0;
				acc_q <= '0;
				over_q <= 1'b0;
			end else begin
				mode_q <= n_mode;
				chars_q <= n_chars;
				count_q <= n_count;
				acc_q <= n_acc;
				over_q <= n_over;
			end
		end
	end

	`SKT_ASSERT_NXT(a_end_clears, accept && end_of_text, mode_q == MODE_IDLE && count_q == 8'd0 && acc_q == 31'd0, "Scanner state not cleared after final character.")
	`SKT_ASSERT_IMP(a_idle_empty, mode_q == MODE_IDLE, count_q == 8'd0 && acc_q == 31'd0 && !over_q, "Idle scanner holds stale word or number state.")

endmodule

@@ rtl/skt_queue.sv @@
// Short queue of token bundles between the front and back parts.
// Uses skt_pkg for the bundle type and depth.
`include "sql_keyword_tokenizer_unit_defines.svh"
module skt_queue import skt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input bundle_t push_data,
	input logic pop,
	output bundle_t head,
	output q_stat_t q_stat
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	bundle_t slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head = slot_q[rd_ptr_q];
	assign q_stat.full = (cnt_q == FULL_CNT);
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`SKT_ASSERT_IMP(a_no_overflow, push, !q_stat.full, "Bundle written into a full queue.")
	`SKT_ASSERT_IMP(a_no_underflow, pop, !q_stat.empty, "Bundle taken from an empty queue.")

endmodule

@@ rtl/skt_back.sv @@
// Back part: walks the head bundle token by token into the output register.
// Uses skt_pkg for the token and bundle types.
`include "sql_keyword_tokenizer_unit_defines.svh"
module skt_back import skt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input bundle_t head,
	input q_stat_t q_stat,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic [4:0] token_kind,
	output logic [63:0] word_text,
	output logic [7:0] word_length,
	output logic [30:0] number_value,
	output logic number_saturated,
	output logic last_of_run
);

	logic [2:0] sent_q, avail, pend, sel;
	logic head_valid, load, is_last;
	token_t tok;
	token_t tok_q;
	logic valid_q, last_q;

	always_comb begin
		head_valid = !q_stat.empty;
		avail = {head.fin, head.v1, head.v0};
		pend = avail & ~sent_q;
		tok = '0;
		tok.kind = TK_END;
		if (pend[0]) begin
			sel = 3'b001;
			tok = head.tok0;
		end else if (pend[1]) begin
			sel = 3'b010;
			tok = head.tok1;
		end else begin
			sel = 3'b100;
		end
		is_last = (pend & ~sel) == 3'b000;
		load = head_valid && (!valid_q || out_ready);
	end

	assign pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sent_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sent_q <= is_last ? 3'b000 : (sent_q | sel);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q <= tok;
			last_q <= is_last;
		end
	end

	assign out_valid = valid_q;
	assign token_kind = tok_q.kind;
	assign word_text = tok_q.text;
	assign word_length = tok_q.len;
	assign number_value = tok_q.val;
	assign number_saturated = tok_q.sat;
	assign last_of_run = last_q;

	`SKT_ASSERT_IMP(a_sent_subset, head_valid, (sent_q & ~avail) == 3'b000, "Sent mask marks a token the head bundle lacks.")
	`SKT_ASSERT_IMP(a_sent_clear, !head_valid, sent_q == 3'b000, "Sent mask not clear while the queue is empty.")

endmodule

@@ test/sql_keyword_tokenizer_unit_test.sv @@
// Self-checking testbench for sql_keyword_tokenizer_unit: it streams characters and checks every
// token against a scanner model that runs alongside the block.
// Depends on skt_pkg and the tokenizer RTL.
module sql_keyword_tokenizer_unit_test;
	import skt_pkg::*;

	localparam int TEXT_CHARS = WORD_CHARS_DEF;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER} scan_mode_t;

	typedef struct {
		logic [7:0] ch;
		logic eot;
		int gap;
		logic drain;
	} char_item_t;

	typedef struct {
		logic [4:0] kind;
		logic [63:0] text;
		logic [7:0] len;
		logic [30:0] val;
		logic sat;
		logic last;
	} token_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] character = 8'h00;
	logic end_of_text = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [4:0] token_kind;
	logic [63:0] word_text;
	logic [7:0] word_length;
	logic [30:0] number_value;
	logic number_saturated;
	logic last_of_run;

	string kw_names [NUM_KEYS] = '{"select", "create", "insert", "into", "table", "values", "from",
		"int", "double", "varchar", "using", "btree", "hash", "update", "where"};

	char_item_t pending [$];
	token_rec_t token_q [$];

	scan_mode_t scan_mode = SCAN_IDLE;
	logic [63:0] word_chars = '0;
	logic [7:0] word_count = '0;
	logic [30:0] number_acc = '0;
	logic number_over = 1'b0;

	int errors = 0;
	int outstanding = 0;
	int chars_scanned = 0;
	int tokens_checked = 0;
	int clamped_ints = 0;
	int long_words = 0;
	logic [23:0] kinds_seen = '0;
	int wait_count = 0;
	int stall_left = 0;
	logic calm_out = 1'b0;
	logic quiet_in = 1'b0;
	logic drain_next = 1'b0;
	token_rec_t got_exp;

	sql_keyword_tokenizer_unit #(.WORD_CHARS(TEXT_CHARS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.character(character),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.word_text(word_text),
		.word_length(word_length),
		.number_value(number_value),
		.number_saturated(number_saturated),
		.last_of_run(last_of_run)
	);

	always #1 clk = ~clk;

	function automatic void emit_token(input logic [4:0] kind, input logic [63:0] text,
			input logic [7:0] len, input logic [30:0] val, input logic sat);
		token_rec_t t;
		t.kind = kind;
		t.text = text;
		t.len = len;
		t.val = val;
		t.sat = sat;
		t.last = 1'b0;
		token_q = {token_q, t};
		kinds_seen[kind] = 1'b1;
		if (sat) clamped_ints++;
		if (len > 8'(TEXT_CHARS)) long_words++;
	endfunction

	function automatic logic [4:0] keyword_kind();
		logic [63:0] packed_kw;
		logic [4:0] kind;
		kind = TK_IDENT;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			packed_kw = '0;
			for (int i = 0; i < kw_names[k].len() && i < 8; i++) begin
				packed_kw[8*i +: 8] = kw_names[k][i];
			end
			if (kw_names[k].len() == int'(word_count) && packed_kw == word_chars) kind = 5'(k);
		end
		return kind;
	endfunction

	function automatic void close_open_token();
		if (scan_mode == SCAN_WORD) begin
			emit_token(keyword_kind(), word_chars, word_count, '0, 1'b0);
		end else if (scan_mode == SCAN_NUMBER) begin
			emit_token(TK_INT, '0, '0, number_acc, number_over);
		end
		scan_mode = SCAN_IDLE;
		word_chars = '0;
		word_count = '0;
		number_acc = '0;
		number_over = 1'b0;
	endfunction

	function automatic void take_letter(input logic [7:0] c);
		if (int'(word_count) < TEXT_CHARS && word_count < 8'd8) word_chars[8*word_count +: 8] = c;
		if (word_count != 8'd255) word_count++;
	endfunction

	function automatic void take_digit(input logic [7:0] c);
		logic [63:0] v;
		v = 64'(number_acc) * 64'd10 + 64'(c - "0");
		if (v > 64'(NUM_MAX)) begin
			number_acc = NUM_MAX;
			number_over = 1'b1;
		end else begin
			number_acc = v[30:0];
		end
	endfunction

	function automatic void scan_char(input logic [7:0] raw, input logic eot);
		logic [7:0] c;
		logic letter;
		logic digit;
		int n_prior;
		n_prior = token_q.size();
		c = raw;
		if (c >= "A" && c <= "Z") c = c + 8'd32;
		letter = c >= "a" && c <= "z";
		digit = c >= "0" && c <= "9";
		if (scan_mode == SCAN_WORD && (letter || digit)) begin
			take_letter(c);
		end else if (scan_mode == SCAN_NUMBER && digit) begin
			take_digit(c);
		end else begin
			close_open_token();
			if (letter) begin
				scan_mode = SCAN_WORD;
				take_letter(c);
			end else if (digit) begin
				scan_mode = SCAN_NUMBER;
				take_digit(c);
			end else if (c == " " || c == 8'h09) begin
			end else if (c == "(") begin
				emit_token(TK_LPAREN, '0, '0, '0, 1'b0);
			end else if (c == ")") begin
				emit_token(TK_RPAREN, '0, '0, '0, 1'b0);
			end else if (c == ";") begin
				emit_token(TK_SEMI, '0, '0, '0, 1'b0);
			end else if (c == "*") begin
				emit_token(TK_STAR, '0, '0, '0, 1'b0);
			end else if (c == ",") begin
				emit_token(TK_COMMA, '0, '0, '0, 1'b0);
			end else begin
				emit_token(TK_UNKNOWN, '0, '0, '0, 1'b0);
			end
		end
		if (eot) begin
			close_open_token();
			emit_token(TK_END, '0, '0, '0, 1'b0);
		end
		if (token_q.size() > n_prior) token_q[token_q.size() - 1].last = 1'b1;
	endfunction

	function automatic void check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			errors++;
		end
	endfunction

	// Sender: each item waits its drawn gap, and a drain item waits for all tokens to arrive.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			character <= 8'h00;
			end_of_text <= 1'b0;
			wait_count = 0;
		end else if (!in_valid || in_ready) begin
			if (pending.size() > 0 && wait_count < pending[0].gap) begin
				wait_count++;
				in_valid <= 1'b0;
			end else if (pending.size() > 0 &&
					(!pending[0].drain || (!in_valid && outstanding == 0))) begin
				character <= pending[0].ch;
				end_of_text <= pending[0].eot;
				in_valid <= 1'b1;
				wait_count = 0;
				void'(pending.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: predicts from accepted characters, then checks and stalls the token side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			outstanding <= 0;
			stall_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				scan_char(character, end_of_text);
				chars_scanned++;
			end
			if (out_valid && out_ready) begin
				if (token_q.size() == 0) begin
					$error("token_kind: expected no token, got %0d", token_kind);
					errors++;
				end else begin
					got_exp = token_q.pop_front();
					check_field("token_kind", 64'(got_exp.kind), 64'(token_kind));
					check_field("word_text", got_exp.text, word_text);
					check_field("word_length", 64'(got_exp.len), 64'(word_length));
					check_field("number_value", 64'(got_exp.val), 64'(number_value));
					check_field("number_saturated", 64'(got_exp.sat), 64'(number_saturated));
					check_field("last_of_run", 64'(got_exp.last), 64'(last_of_run));
				end
				tokens_checked++;
				stall_left = calm_out ? 0 : $urandom_range(0, 3);
				if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_ready <= (stall_left == 0);
			outstanding <= token_q.size();
		end
	end

	function automatic logic [7:0] mixed_case(input logic [7:0] c);
		if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
		return c;
	endfunction

	function automatic void push_char(input logic [7:0] c, input logic eot);
		char_item_t it;
		it.ch = c;
		it.eot = eot;
		it.gap = quiet_in ? 0 : $urandom_range(0, 3);
		it.drain = drain_next;
		drain_next = 1'b0;
		pending = {pending, it};
	endfunction

	function automatic void push_text(input string s, input logic fold);
		for (int i = 0; i < s.len(); i++) begin
			push_char(fold ? mixed_case(s[i]) : s[i], 1'b0);
		end
	endfunction

	function automatic void push_word_char();
		if ($urandom_range(0, 3) == 0) push_char(8'("0") + 8'($urandom_range(0, 9)), 1'b0);
		else push_char(mixed_case(8'("a") + 8'($urandom_range(0, 25))), 1'b0);
	endfunction

	function automatic void push_token();
		string s;
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2: push_text(kw_names[$urandom_range(0, NUM_KEYS - 1)], 1'b1);
			3: begin
				s = kw_names[$urandom_range(0, NUM_KEYS - 1)];
				case ($urandom_range(0, 2))
					0: push_text(s.substr(0, s.len() - 2), 1'b1);
					1: begin
						push_text(s, 1'b1);
						push_word_char();
					end
					default: begin
						push_char(mixed_case(8'("a") + 8'($urandom_range(0, 25))), 1'b0);
						n = $urandom_range(0, 11);
						repeat (n) push_word_char();
					end
				endcase
			end
			4: begin
				case ($urandom_range(0, 5))
					0: push_text("2147483647", 1'b0);
					1: push_text("2147483648", 1'b0);
					default: begin
						n = $urandom_range(1, 12);
						repeat (n) push_char(8'("0") + 8'($urandom_range(0, 9)), 1'b0);
					end
				endcase
			end
			5, 6: begin
				s = "()*;,";
				push_char(s[$urandom_range(0, 4)], 1'b0);
			end
			7: push_char(8'($urandom_range(0, 255)), 1'b0);
			default: begin
			end
		endcase
		case ($urandom_range(0, 3))
			0: push_char(8'h09, 1'b0);
			1, 2: push_char(" ", 1'b0);
			default: begin
			end
		endcase
	endfunction

	function automatic void push_statement();
		int n;
		n = $urandom_range(1, 8);
		if ($urandom_range(0, 4) == 0) drain_next = 1'b1;
		if ($urandom_range(0, 5) == 0) quiet_in = !quiet_in;
		repeat (n) push_token();
		if (pending.size() > 0 && $urandom_range(0, 2) == 0) begin
			pending[pending.size() - 1].eot = 1'b1;
		end else begin
			push_char(";", 1'b1);
		end
	endfunction

	initial begin
		int floor_n;
		push_text("Select(9)*,", 1'b0);
		push_char(8'h09, 1'b0);
		push_char(";", 1'b0);
		push_char(8'h00, 1'b0);
		push_char(8'hFF, 1'b0);
		push_text("Z0 9x", 1'b0);
		push_char(8'h7F, 1'b0);
		push_char(8'h80, 1'b0);
		push_char("q", 1'b1);
		push_char("a", 1'b0);
		push_char("(", 1'b1);
		push_char(")", 1'b1);

		drain_next = 1'b1;
		for (int k = 0; k < NUM_KEYS; k++) begin
			push_text(kw_names[k], 1'b1);
			push_char(" ", 1'b0);
		end
		push_char("w", 1'b0);
		repeat (14) push_word_char();
		push_char(";", 1'b1);
		floor_n = pending.size() + 30;
		while (pending.size() < floor_n) push_statement();

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (pending.size() > 0 || in_valid || outstanding != 0 || token_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Scanned %0d characters and checked %0d tokens, %0d of 24 token kinds seen.",
			chars_scanned, tokens_checked, $countones(kinds_seen));
		$display("Clamped integers: %0d; words longer than the stored text: %0d.",
			clamped_ints, long_words);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/skt_pkg.sv
rtl/skt_front.sv
rtl/skt_queue.sv
rtl/skt_back.sv
rtl/sql_keyword_tokenizer_unit.sv
test/sql_keyword_tokenizer_unit_test.sv
